// File: design/rew_pkg.sv
// Shared constants and saturation helpers for the raster edge walker.
// Used by the top level and by the serial divider and multiplier units.
// No dependencies.
package rew_pkg;

  localparam int DATA_W        = 32;
  localparam int LINE_W        = 16;
  localparam int ACC_W         = DATA_W + 2;
  localparam int NUM_ATTR      = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_TDATA_W    = 8 * DATA_W;
  localparam int OUT_TDATA_W   = 2 * LINE_W + 5 * DATA_W;
  localparam int CFG_IDX_W     = 3;

  localparam logic CMD_SETUP = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [LINE_W-1:0] MAX16 = {1'b0, {(LINE_W-1){1'b1}}};
  localparam logic signed [LINE_W-1:0] MIN16 = {1'b1, {(LINE_W-1){1'b0}}};

  // Clamp a 37-bit sum to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [36:0] v);
    logic [36-DATA_W+1:0] hi;
    hi = v[36:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      return v[DATA_W-1:0];
    end
    return v[36] ? MIN32 : MAX32;
  endfunction

  // Clamp a 33-bit line number to the signed 16-bit range
  function automatic logic signed [LINE_W-1:0] sat16(input logic signed [DATA_W:0] v);
    logic [DATA_W-LINE_W+1:0] hi;
    hi = v[DATA_W:LINE_W-1];
    if (hi == '0 || hi == '1) begin
      return v[LINE_W-1:0];
    end
    return v[DATA_W] ? MIN16 : MAX16;
  endfunction

endpackage

// File: design/rew_div.sv
// Bit-serial restoring divider for the edge x step: (dx << FRAC_BITS) / dy,
// truncated toward zero and saturated to 32 bits. One quotient bit per cycle.
// Depends on rew_pkg.
module rew_div #(
  parameter int FRAC_BITS = rew_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [rew_pkg::DATA_W:0]   dividend,
  input  logic signed [rew_pkg::DATA_W:0]   divisor,
  output logic                              done,
  output logic signed [rew_pkg::DATA_W-1:0] quot
);

  localparam int DW    = rew_pkg::DATA_W;
  localparam int NUM_W = DW + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(DW);

  logic [DW:0]        dvd_mag;
  logic [DW:0]        dvs_mag;
  logic [NUM_W-1:0]   num_full;
  logic [DW:0]        num_hi;
  logic [DW:0]        rem_r;
  logic [DW:0]        rem_nxt;
  logic [DW-1:0]      ql_r;
  logic [DW-1:0]      ql_nxt;
  logic [DW:0]        d_r;
  logic               neg_r;
  logic               ovf_r;
  logic [DW+1:0]      sh;
  logic [DW+1:0]      diff;
  logic               ge;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic               last;
  logic signed [DW-1:0] quot_r;
  logic signed [DW-1:0] quot_nxt;

  // Operand magnitudes and the scaled dividend split at bit 32
  assign dvd_mag  = dividend[DW] ? DW'(1'b0) - dividend : dividend;
  assign dvs_mag  = divisor[DW]  ? DW'(1'b0) - divisor  : divisor;
  assign num_full = {dvd_mag, {FRAC_BITS{1'b0}}};
  assign num_hi   = {{(DW - FRAC_BITS){1'b0}}, num_full[NUM_W-1:DW]};

  // One restoring step: shift in the next dividend bit, subtract when it fits
  assign sh      = {rem_r, ql_r[DW-1]};
  assign diff    = sh - {1'b0, d_r};
  assign ge      = (sh >= {1'b0, d_r});
  assign rem_nxt = ge ? diff[DW:0] : sh[DW:0];
  assign ql_nxt  = {ql_r[DW-2:0], ge};
  assign last    = (cnt_r == CNT_W'(DW - 1));

  // Apply the sign and clamp to the signed 32-bit range
  always_comb begin
    if (!neg_r) begin
      quot_nxt = (ovf_r || ql_nxt[DW-1]) ? rew_pkg::MAX32 : ql_nxt;
    end else if (ovf_r || (ql_nxt[DW-1] && (|ql_nxt[DW-2:0]))) begin
      quot_nxt = rew_pkg::MIN32;
    end else begin
      quot_nxt = DW'(1'b0) - ql_nxt;
    end
  end

  // Control: iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      ql_r  <= num_full[DW-1:0];
      d_r   <= dvs_mag;
      neg_r <= dividend[DW] ^ divisor[DW];
      ovf_r <= (num_hi >= dvs_mag);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      ql_r  <= ql_nxt;
      if (last) begin
        quot_r <= quot_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: design/rew_smul.sv
// Bit-serial signed shift-add multiplier: 32-bit multiplicand times an
// MP_W-bit two's complement multiplier, one multiplier bit per cycle.
// Depends on rew_pkg.
module rew_smul #(
  parameter int MP_W = rew_pkg::DATA_W + 1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic signed [rew_pkg::DATA_W-1:0]       mcand,
  input  logic [MP_W-1:0]                         mplier,
  output logic                                    done,
  output logic signed [rew_pkg::ACC_W+MP_W-1:0]   prod
);

  localparam int DW    = rew_pkg::DATA_W;
  localparam int AW    = rew_pkg::ACC_W;
  localparam int CNT_W = $clog2(MP_W);

  logic signed [DW-1:0] mc_r;
  logic signed [AW-1:0] acc_r;
  logic [MP_W-1:0]      lo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 last;
  logic signed [AW-1:0] mc_ext;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] sum;

  // Add the multiplicand for a set bit; the top bit carries negative weight
  assign last   = (cnt_r == CNT_W'(MP_W - 1));
  assign mc_ext = AW'(mc_r);
  always_comb begin
    if (!lo_r[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -mc_ext;
    end else begin
      addend = mc_ext;
    end
  end
  assign sum = acc_r + addend;

  // Control: bit count and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right; product bits fill in as multiplier bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      acc_r <= '0;
      lo_r  <= mplier;
    end else if (busy_r) begin
      acc_r <= {sum[AW-1], sum[AW-1:1]};
      lo_r  <= {sum[0], lo_r[MP_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {acc_r, lo_r};

endmodule

// File: design/raster_edge_walker.sv
// Scanline edge walker with sub-pixel prestep, built from bit-serial units.
// Setup item: the result follows the serial divider and then the (FRAC_BITS+1)-bit
// x prestep multiply and the 33-bit attribute multiplies. Step item: the x and
// attribute steps are added to the edge state without the serial units.
// Reset (rst_n low, synchronous) clears edge state and gradient registers to zero.
// Depends on rew_pkg, rew_div and rew_smul.
module raster_edge_walker #(
  parameter int FRAC_BITS = rew_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, low bit up: start_x, start_y, end_x, end_y,
  // start_u, start_v, start_invz, start_depth
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rew_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,    // command
  // out_tdata, low bit up: first_line, last_line, edge_x, edge_u,
  // edge_v, edge_invz, edge_depth
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rew_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,   // degenerate
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rew_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rew_pkg::DATA_W-1:0]        cfg_data
);

  localparam int DW       = rew_pkg::DATA_W;
  localparam int LW       = rew_pkg::LINE_W;
  localparam int NA       = rew_pkg::NUM_ATTR;
  localparam int Y_PW     = rew_pkg::ACC_W + FRAC_BITS + 1;
  localparam int XP_PW    = rew_pkg::ACC_W + DW + 1;
  localparam int S_PW     = rew_pkg::ACC_W + DW;
  localparam int T_W      = 36;

  localparam int ATTR_U     = 0;
  localparam int ATTR_V     = 1;
  localparam int ATTR_INVZ  = 2;
  localparam int ATTR_DEPTH = 3;

  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  typedef enum logic [rew_pkg::CFG_IDX_W-1:0] {
    CFG_U_XSTEP     = 3'd0,
    CFG_U_YSTEP     = 3'd1,
    CFG_V_XSTEP     = 3'd2,
    CFG_V_YSTEP     = 3'd3,
    CFG_INVZ_XSTEP  = 3'd4,
    CFG_INVZ_YSTEP  = 3'd5,
    CFG_DEPTH_XSTEP = 3'd6,
    CFG_DEPTH_YSTEP = 3'd7
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_DSTART = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_XMUL   = 8'b0001_0000,
    S_XP     = 8'b0010_0000,
    S_XPMUL  = 8'b0100_0000,
    S_PUSH   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Gradient registers
  logic signed [DW-1:0] xstep_r [NA];
  logic signed [DW-1:0] ystep_r [NA];

  // Edge state
  logic signed [LW-1:0] line_first_r;
  logic signed [LW-1:0] line_last_r;
  logic signed [DW-1:0] x_now_r;
  logic signed [DW-1:0] x_inc_r;
  logic signed [DW-1:0] now_r [NA];
  logic signed [DW-1:0] inc_r [NA];
  logic                 flat_r;

  // Setup operands and intermediates
  logic signed [DW-1:0] sx_r;
  logic signed [DW-1:0] sy_r;
  logic signed [DW-1:0] ex_r;
  logic signed [DW-1:0] ey_r;
  logic signed [DW-1:0] st_r [NA];
  logic signed [DW:0]   dx_r;
  logic signed [DW:0]   dy_r;
  logic [FRAC_BITS-1:0] yp_r;
  logic signed [DW:0]   base_r [NA];

  // Output register
  logic                          out_tvalid_r;
  logic [rew_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                          out_tuser_r;

  logic                 in_accept;
  logic                 out_free;
  logic [FRAC_BITS-1:0] yp_nxt;
  logic [FRAC_BITS-1:0] ype_nxt;
  logic signed [DW:0]   cy_s;
  logic signed [DW:0]   cy_e;
  logic signed [DW:0]   dx_nxt;
  logic signed [DW:0]   dy_nxt;
  logic signed [DW-1:0] xinc_nxt;
  logic signed [DW:0]   xp_mp;
  logic signed [DW-1:0] x_fl;
  logic signed [DW-1:0] x_step;
  logic signed [DW-1:0] x_set;
  logic signed [DW-1:0] y_fl [NA];
  logic signed [DW:0]   base_nxt [NA];
  logic signed [T_W-1:0] xp_t [NA];
  logic signed [T_W-1:0] s_t [NA];
  logic signed [DW-1:0] now_step [NA];
  logic signed [DW-1:0] now_set [NA];
  logic signed [DW-1:0] inc_set [NA];

  logic                 y_start;
  logic                 div_start;
  logic                 x_start;
  logic                 xp_start;
  logic                 div_done;
  logic signed [DW-1:0] div_quot;
  logic                 x_done;
  logic signed [Y_PW-1:0] x_prod;
  logic signed [Y_PW-1:0] y_prod [NA];
  logic signed [XP_PW-1:0] xp_prod [NA];
  logic signed [S_PW-1:0]  s_prod [NA];
  logic [NA-1:0]        xp_done;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Prestep fractions and scanline ceilings
  assign yp_nxt  = '0 - sy_r[FRAC_BITS-1:0];
  assign ype_nxt = '0 - ey_r[FRAC_BITS-1:0];
  assign cy_s    = {sy_r[DW-1], sy_r} + {{(DW + 1 - FRAC_BITS){1'b0}}, yp_nxt};
  assign cy_e    = {ey_r[DW-1], ey_r} + {{(DW + 1 - FRAC_BITS){1'b0}}, ype_nxt};
  assign dx_nxt  = {ex_r[DW-1], ex_r} - {sx_r[DW-1], sx_r};
  assign dy_nxt  = {ey_r[DW-1], ey_r} - {sy_r[DW-1], sy_r};

  // x step, x prestep and the x offset that the attributes follow
  assign xinc_nxt = flat_r ? '0 : div_quot;
  assign x_fl     = x_prod[FRAC_BITS+DW-1:FRAC_BITS];
  assign x_set    = rew_pkg::sat32(37'(sx_r) + 37'(x_fl));
  assign x_step   = rew_pkg::sat32(37'(x_now_r) + 37'(x_inc_r));
  assign xp_mp    = {x_now_r[DW-1], x_now_r} - {sx_r[DW-1], sx_r};

  // Unit start strobes
  assign y_start   = (state_r == S_PREP);
  assign div_start = (state_r == S_DSTART);
  assign x_start   = (state_r == S_DIV) && div_done;
  assign xp_start  = (state_r == S_XP);

  rew_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dx_r),
    .divisor  (dy_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  rew_smul #(.MP_W(FRAC_BITS + 1)) u_xmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (x_start),
    .mcand  (xinc_nxt),
    .mplier ({1'b0, yp_r}),
    .done   (x_done),
    .prod   (x_prod)
  );

  for (genvar a = 0; a < NA; a++) begin : g_attr
    // ystep * y prestep, runs beside the divider
    rew_smul #(.MP_W(FRAC_BITS + 1)) u_ymul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (y_start),
      .mcand  (ystep_r[a]),
      .mplier ({1'b0, yp_nxt}),
      .done   (),
      .prod   (y_prod[a])
    );

    // xstep * x prestep offset
    rew_smul #(.MP_W(DW + 1)) u_xpmul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (xp_start),
      .mcand  (xstep_r[a]),
      .mplier (xp_mp),
      .done   (xp_done[a]),
      .prod   (xp_prod[a])
    );

    // xstep * x step for the per-scanline attribute step
    rew_smul #(.MP_W(DW)) u_smul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (x_start),
      .mcand  (xstep_r[a]),
      .mplier (xinc_nxt),
      .done   (),
      .prod   (s_prod[a])
    );
  end

  // Per-attribute sums: floor the products, clamp wide terms, saturate
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      y_fl[a]     = y_prod[a][FRAC_BITS+DW-1:FRAC_BITS];
      base_nxt[a] = (DW + 1)'(st_r[a]) + (DW + 1)'(y_fl[a]);

      if (xp_prod[a][XP_PW-1:FRAC_BITS+T_W-1] == '0 ||
          xp_prod[a][XP_PW-1:FRAC_BITS+T_W-1] == '1) begin
        xp_t[a] = xp_prod[a][FRAC_BITS+T_W-1:FRAC_BITS];
      end else begin
        xp_t[a] = xp_prod[a][XP_PW-1] ? T_MIN : T_MAX;
      end

      if (s_prod[a][S_PW-1:FRAC_BITS+T_W-1] == '0 ||
          s_prod[a][S_PW-1:FRAC_BITS+T_W-1] == '1) begin
        s_t[a] = s_prod[a][FRAC_BITS+T_W-1:FRAC_BITS];
      end else begin
        s_t[a] = s_prod[a][S_PW-1] ? T_MIN : T_MAX;
      end

      now_set[a]  = rew_pkg::sat32(37'(base_r[a]) + 37'(xp_t[a]));
      inc_set[a]  = rew_pkg::sat32(37'(ystep_r[a]) + 37'(s_t[a]));
      now_step[a] = rew_pkg::sat32(37'(now_r[a]) + 37'(inc_r[a]));
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_tuser == rew_pkg::CMD_STEP) ? S_PUSH : S_PREP;
        end
      end
      S_PREP:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_XMUL;
        end
      end
      S_XMUL: begin
        if (x_done) begin
          state_nxt = S_XP;
        end
      end
      S_XP:     state_nxt = S_XPMUL;
      S_XPMUL: begin
        if (&xp_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control, gradient registers and edge state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      line_first_r <= '0;
      line_last_r  <= '0;
      x_now_r      <= '0;
      x_inc_r      <= '0;
      flat_r       <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        xstep_r[a] <= '0;
        ystep_r[a] <= '0;
        now_r[a]   <= '0;
        inc_r[a]   <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Drop the result once the transfer completes
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_U_XSTEP:     xstep_r[ATTR_U]     <= cfg_data;
          CFG_U_YSTEP:     ystep_r[ATTR_U]     <= cfg_data;
          CFG_V_XSTEP:     xstep_r[ATTR_V]     <= cfg_data;
          CFG_V_YSTEP:     ystep_r[ATTR_V]     <= cfg_data;
          CFG_INVZ_XSTEP:  xstep_r[ATTR_INVZ]  <= cfg_data;
          CFG_INVZ_YSTEP:  ystep_r[ATTR_INVZ]  <= cfg_data;
          CFG_DEPTH_XSTEP: xstep_r[ATTR_DEPTH] <= cfg_data;
          CFG_DEPTH_YSTEP: ystep_r[ATTR_DEPTH] <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          // Advance one scanline
          if (in_accept && in_tuser == rew_pkg::CMD_STEP) begin
            x_now_r <= x_step;
            for (int a = 0; a < NA; a++) begin
              now_r[a] <= now_step[a];
            end
          end
        end
        S_PREP: begin
          line_first_r <= rew_pkg::sat16(cy_s >>> FRAC_BITS);
          line_last_r  <= rew_pkg::sat16(cy_e >>> FRAC_BITS);
          flat_r       <= (dy_nxt == '0);
        end
        S_DIV: begin
          if (div_done) begin
            x_inc_r <= xinc_nxt;
          end
        end
        S_XMUL: begin
          if (x_done) begin
            x_now_r <= x_set;
          end
        end
        S_XPMUL: begin
          if (&xp_done) begin
            for (int a = 0; a < NA; a++) begin
              now_r[a] <= now_set[a];
              inc_r[a] <= inc_set[a];
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: setup operands, intermediates and the output register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_accept && in_tuser == rew_pkg::CMD_SETUP) begin
      sx_r <= in_tdata[0*DW +: DW];
      sy_r <= in_tdata[1*DW +: DW];
      ex_r <= in_tdata[2*DW +: DW];
      ey_r <= in_tdata[3*DW +: DW];
      for (int a = 0; a < NA; a++) begin
        st_r[a] <= in_tdata[(4 + a)*DW +: DW];
      end
    end
    if (state_r == S_PREP) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      yp_r <= yp_nxt;
    end
    if (x_start) begin
      for (int a = 0; a < NA; a++) begin
        base_r[a] <= base_nxt[a];
      end
    end
    if (state_r == S_PUSH && out_free) begin
      out_tdata_r <= {now_r[ATTR_DEPTH], now_r[ATTR_INVZ], now_r[ATTR_V],
                      now_r[ATTR_U], x_now_r, line_last_r, line_first_r};
      out_tuser_r <= flat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: dv/tb_raster_edge_walker.sv
// Self-checking testbench for raster_edge_walker: edge setup and scanline stepping.
// A built-in predictor computes expected edge state for each accepted transfer.
// Depends on rew_pkg and the raster_edge_walker RTL.
`timescale 1ns / 1ps

module tb_raster_edge_walker;
  import rew_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int QUIET_MAX  = 3000;
  localparam int PRINT_MAX  = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 166;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_U_XSTEP, REG_U_YSTEP, REG_V_XSTEP, REG_V_YSTEP,
    REG_INVZ_XSTEP, REG_INVZ_YSTEP, REG_DEPTH_XSTEP, REG_DEPTH_YSTEP
  } grad_reg_e;

  typedef enum int {ATTR_U, ATTR_V, ATTR_INVZ, ATTR_DEPTH} attr_e;
  typedef enum int {GRAD_MIN, GRAD_FULL, GRAD_SMALL, GRAD_ZERO, GRAD_MIXED, GRAD_MAX} grad_mode_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Field order matches the tdata packing, lowest field last
  typedef struct packed {
    logic                           cmd;
    logic signed [3:0][DATA_W-1:0]  attr;
    logic signed [DATA_W-1:0]       end_y;
    logic signed [DATA_W-1:0]       end_x;
    logic signed [DATA_W-1:0]       start_y;
    logic signed [DATA_W-1:0]       start_x;
  } edge_item_t;

  typedef struct packed {
    logic                           degenerate;
    logic signed [3:0][DATA_W-1:0]  attr;
    logic signed [DATA_W-1:0]       x;
    logic signed [LINE_W-1:0]       last_line;
    logic signed [LINE_W-1:0]       first_line;
  } edge_state_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;     // start_x, start_y, end_x, end_y, u, v, invz, depth
  logic                    in_tuser;     // command
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;    // first_line, last_line, x, u, v, invz, depth
  logic                    out_tuser;    // degenerate
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DATA_W-1:0]       cfg_data;

  // Predictor state: gradients and current edge
  logic signed [DATA_W-1:0] grad_x [4];
  logic signed [DATA_W-1:0] grad_y [4];
  logic signed [LINE_W-1:0] line_top;
  logic signed [LINE_W-1:0] line_bottom;
  logic signed [DATA_W-1:0] x_pos;
  logic signed [DATA_W-1:0] x_slope;
  logic signed [DATA_W-1:0] attr_pos [4];
  logic signed [DATA_W-1:0] attr_slope [4];
  logic                     flat_q;

  edge_item_t  pending_items [$];
  edge_state_t expected_states [$];
  edge_item_t  item_on_bus;
  int          items_issued;
  int          results_seen;
  int          mismatches;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  string       attr_names [4] = '{"edge_u", "edge_v", "edge_invz", "edge_depth"};

  raster_edge_walker #(.FRAC_BITS(FRAC)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > longint'(MAX32)) return MAX32;
    if (v < longint'(MIN32)) return MIN32;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [LINE_W-1:0] clamp16(input longint v);
    if (v > longint'(MAX16)) return MAX16;
    if (v < longint'(MIN16)) return MIN16;
    return v[LINE_W-1:0];
  endfunction

  // Distance from y up to the next whole scanline
  function automatic longint frac_to_line(input longint y);
    longint mask;
    mask = (longint'(1) << FRAC) - 1;
    return (-y) & mask;
  endfunction

  function automatic edge_state_t walk_edge(input edge_item_t it);
    edge_state_t r;
    longint sx, sy, ex, ey, dy, yp, xp, xs, ys;
    if (it.cmd == CMD_SETUP) begin
      sx = longint'(it.start_x);
      sy = longint'(it.start_y);
      ex = longint'(it.end_x);
      ey = longint'(it.end_y);
      dy = ey - sy;
      line_top    = clamp16((sy + frac_to_line(sy)) >>> FRAC);
      line_bottom = clamp16((ey + frac_to_line(ey)) >>> FRAC);
      if (dy == 0) begin
        x_slope = '0;
        flat_q  = 1'b1;
      end else begin
        // Division truncates toward zero
        x_slope = clamp32(((ex - sx) <<< FRAC) / dy);
        flat_q  = 1'b0;
      end
      yp    = frac_to_line(sy);
      x_pos = clamp32(sx + ((yp * longint'(x_slope)) >>> FRAC));
      xp    = longint'(x_pos) - sx;
      for (int a = 0; a < 4; a++) begin
        xs = longint'(grad_x[a]);
        ys = longint'(grad_y[a]);
        attr_pos[a]   = clamp32(longint'($signed(it.attr[a])) + ((ys * yp) >>> FRAC)
                                + ((xs * xp) >>> FRAC));
        attr_slope[a] = clamp32(ys + ((xs * longint'(x_slope)) >>> FRAC));
      end
    end else begin
      x_pos = clamp32(longint'(x_pos) + longint'(x_slope));
      for (int a = 0; a < 4; a++) begin
        attr_pos[a] = clamp32(longint'(attr_pos[a]) + longint'(attr_slope[a]));
      end
    end
    r.first_line = line_top;
    r.last_line  = line_bottom;
    r.x          = x_pos;
    for (int a = 0; a < 4; a++) begin
      r.attr[a] = attr_pos[a];
    end
    r.degenerate = flat_q;
    return r;
  endfunction

  function automatic void apply_gradient(input grad_reg_e idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_U_XSTEP:     grad_x[ATTR_U]     = val;
      REG_U_YSTEP:     grad_y[ATTR_U]     = val;
      REG_V_XSTEP:     grad_x[ATTR_V]     = val;
      REG_V_YSTEP:     grad_y[ATTR_V]     = val;
      REG_INVZ_XSTEP:  grad_x[ATTR_INVZ]  = val;
      REG_INVZ_YSTEP:  grad_y[ATTR_INVZ]  = val;
      REG_DEPTH_XSTEP: grad_x[ATTR_DEPTH] = val;
      REG_DEPTH_YSTEP: grad_y[ATTR_DEPTH] = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_MAX) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [DATA_W-1:0] rand_span(input int whole);
    return int'($urandom_range(0, (2 * whole) << FRAC)) - (whole << FRAC);
  endfunction

  function automatic edge_item_t make_item(input logic cmd,
      input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
      input logic [DATA_W-1:0] ex, input logic [DATA_W-1:0] ey,
      input logic [DATA_W-1:0] attr_val);
    edge_item_t it;
    it.cmd     = cmd;
    it.start_x = sx;
    it.start_y = sy;
    it.end_x   = ex;
    it.end_y   = ey;
    for (int a = 0; a < 4; a++) begin
      it.attr[a] = attr_val ^ (a << 8);
    end
    return it;
  endfunction

  function automatic edge_item_t random_item(input logic cmd);
    edge_item_t it;
    it.cmd     = cmd;
    it.start_x = $urandom;
    it.start_y = $urandom;
    it.end_x   = $urandom;
    it.end_y   = $urandom;
    for (int a = 0; a < 4; a++) begin
      it.attr[a] = $urandom;
    end
    return it;
  endfunction

  task automatic queue_item(input edge_item_t it);
    pending_items.push_back(it);
    items_issued++;
  endtask

  // Corners: flat edge, saturated slope, lines off the 16-bit range, stepping into limits
  task automatic queue_directed();
    queue_item(make_item(CMD_STEP, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_SETUP, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_SETUP, 32'h0001_0000, 32'h0001_8000, 32'h000A_0000,
                         32'h0001_8000, 32'h0003_4000));
    queue_item(make_item(CMD_STEP, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_SETUP, MIN32, 32'h0000_0000, MAX32, 32'h0000_0001, MAX32));
    queue_item(make_item(CMD_STEP, '1, '1, '1, '1, '1));
    queue_item(make_item(CMD_STEP, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_SETUP, MAX32, MIN32, MIN32, MAX32, MIN32));
    queue_item(make_item(CMD_STEP, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_SETUP, 32'h5555_5555, 32'h7FFF_0001, 32'hAAAA_AAAA, MIN32,
                         32'h5555_5555));
    queue_item(make_item(CMD_SETUP, 32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFF9,
                         32'hFFFB_0000, 32'hAAAA_AAAA));
    queue_item(make_item(CMD_STEP, '0, '0, '0, '0, '0));
  endtask

  // One edge setup followed by the scanline steps that walk it
  task automatic queue_edge_run();
    edge_item_t it;
    int         steps;
    it.cmd     = CMD_SETUP;
    it.start_y = rand_span(2000);
    it.end_y   = ($urandom_range(0, 9) == 0) ? it.start_y : it.start_y + rand_span(64);
    it.start_x = rand_span(4000);
    it.end_x   = rand_span(4000);
    for (int a = 0; a < 4; a++) begin
      it.attr[a] = $urandom_range(0, 1) ? $urandom : rand_span(256);
    end
    queue_item(it);
    steps = $urandom_range(0, 16);
    repeat (steps) queue_item(random_item(CMD_STEP));
  endtask

  function automatic logic [DATA_W-1:0] pick_gradient(input grad_mode_e mode);
    case (mode)
      GRAD_MIN:   return MIN32;
      GRAD_MAX:   return MAX32;
      GRAD_ZERO:  return '0;
      GRAD_SMALL: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
      GRAD_MIXED: begin
        case ($urandom_range(0, 2))
          0:       return MIN32;
          1:       return MAX32;
          default: return $urandom;
        endcase
      end
      default:    return $urandom;
    endcase
  endfunction

  // Leaves cfg_valid high after the last transfer; caller lowers it
  task automatic write_gradient(input grad_reg_e idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_gradient(idx, val);
  endtask

  task automatic write_all_gradients(input grad_mode_e mode);
    grad_reg_e r;
    r = r.first();
    repeat (r.num()) begin
      write_gradient(r, pick_gradient(mode));
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 73 : (mode == IDLE_BOTH) ? 27 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 27 : 0;
  endtask

  task automatic wait_drained();
    while (results_seen != items_issued) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_states.push_back(walk_edge(item_on_bus));
      end
      // Hold the transfer until accepted, then offer the next one
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= item_on_bus.cmd;
          in_tdata  <= {item_on_bus.attr, item_on_bus.end_y, item_on_bus.end_x,
                        item_on_bus.start_y, item_on_bus.start_x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    edge_state_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_states.pop_front();
          check_field("first_line", longint'($signed(out_tdata[15:0])),
                      longint'(want.first_line));
          check_field("last_line", longint'($signed(out_tdata[31:16])),
                      longint'(want.last_line));
          check_field("edge_x", longint'($signed(out_tdata[63:32])), longint'(want.x));
          for (int a = 0; a < 4; a++) begin
            check_field(attr_names[a], longint'($signed(out_tdata[64 + 32 * a +: 32])),
                        longint'($signed(want.attr[a])));
          end
          check_field("degenerate", longint'(out_tuser), longint'(want.degenerate));
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase_start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    items_issued = 0;
    results_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    for (int a = 0; a < 4; a++) begin
      grad_x[a]     = '0;
      grad_y[a]     = '0;
      attr_pos[a]   = '0;
      attr_slope[a] = '0;
    end
    line_top    = '0;
    line_bottom = '0;
    x_pos       = '0;
    x_slope     = '0;
    flat_q      = 1'b0;
    set_idle(IDLE_NONE);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Corners at reset gradients, starting with a step before any setup
    queue_directed();
    wait_drained();

    // Same corners with every gradient at its positive limit
    write_all_gradients(GRAD_MAX);
    set_idle(IDLE_SENDER);
    queue_directed();
    wait_drained();

    // Random edges under rotating gradients and flow control
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_all_gradients(grad_mode_e'(p % 5));
      set_idle(idle_mode_e'(p % 4));
      phase_start = items_issued;
      while (items_issued - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_edge_run();
        end else begin
          repeat ($urandom_range(1, 3)) queue_item(random_item($urandom_range(0, 1)));
        end
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (expected_states.size() != 0) begin
      report_mismatch("results never delivered", expected_states.size(), 0);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
